// ===== rtl/core/ubps_pkg.sv =====
`default_nettype none

package ubps_pkg;

	// Defaults of the top-level parameters
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int LINE_BUFFER_DEF = 96;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int PCT_W   = 7;
	localparam int SCORE_W = 32;
	localparam int TOTAL_W = 24;
	localparam int LEN_W   = 7;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Divider produces one quotient bit per step; the percentage never exceeds 100
	localparam int DIV_STEPS = 7;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
	localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
	localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7E;
	localparam logic [BYTE_W-1:0] UBX_SYNC1  = 8'hB5;
	localparam logic [BYTE_W-1:0] UBX_SYNC2  = 8'h62;

	// Score weights
	localparam int W_DOLLAR = 300;
	localparam int W_NMEA   = 1000;
	localparam int W_UBX    = 1000;
	localparam int W_BONUS  = 200;
	localparam int W_BITS   = 10;

	// Shortest line that counts as NMEA
	localparam int NMEA_MIN_LEN = 6;

	// Register indexes
	typedef enum logic [0:0] {
		CFG_MIN_BYTES = 1'b0,
		CFG_PCT_MIN   = 1'b1
	} cfg_idx_t;

	// Operation codes
	typedef enum logic [0:0] {
		OP_DATA  = 1'b0,
		OP_CLOSE = 1'b1
	} op_t;

	// Configuration seen by the back end
	typedef struct packed {
		logic [BYTE_W-1:0] min_bytes;
		logic [PCT_W-1:0]  pct_min;
	} cfg_t;

	// Classified request as queued between front and back
	typedef struct packed {
		logic              close;
		logic              printable;
		logic              dollar;
		logic              eol;
		logic              is_g;
		logic              is_sync1;
		logic              is_sync2;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/ubps_if.sv =====
`default_nettype none

// Input request channel
interface ubps_item_if;
	import ubps_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Report channel
interface ubps_result_if;
	import ubps_pkg::*;

	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;
	logic               plausible;
	logic [TOTAL_W-1:0] total_bytes;
	logic [PCT_W-1:0]   printable_percent;
	logic [TOTAL_W-1:0] dollar_total;
	logic [TOTAL_W-1:0] nmea_total;
	logic [TOTAL_W-1:0] ubx_sync_total;

	modport source (output valid, output score, output plausible, output total_bytes,
		output printable_percent, output dollar_total, output nmea_total,
		output ubx_sync_total, input ready);
	modport sink (input valid, input score, input plausible, input total_bytes,
		input printable_percent, input dollar_total, input nmea_total,
		input ubx_sync_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ubps_front.sv =====
`default_nettype none

module ubps_front (
	ubps_item_if.sink          item,
	input  wire logic          full,
	output logic               push,
	output ubps_pkg::entry_t   push_data
);
	import ubps_pkg::*;

	// Take a request whenever the queue has room
	assign item.ready = !full;
	assign push       = item.valid && !full;

	// Classify the byte once so the back end only sees flags
	always_comb begin
		push_data.close     = (item.operation == OP_CLOSE);
		push_data.printable = (item.data_byte >= CH_SPACE) && (item.data_byte <= CH_TILDE);
		push_data.dollar    = (item.data_byte == CH_DOLLAR);
		push_data.eol       = (item.data_byte == CH_CR) || (item.data_byte == CH_LF);
		push_data.is_g      = (item.data_byte == CH_G);
		push_data.is_sync1  = (item.data_byte == UBX_SYNC1);
		push_data.is_sync2  = (item.data_byte == UBX_SYNC2);
	end

endmodule

`default_nettype wire

// ===== rtl/core/ubps_fifo.sv =====
`default_nettype none

module ubps_fifo #(
	parameter int DEPTH = ubps_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ubps_pkg::entry_t push_data,
	input  wire logic             pop,
	output logic                  full,
	output logic                  rd_valid,
	output ubps_pkg::entry_t      rd_data
);
	import ubps_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("pop did not lower the count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ubps_back.sv =====
`default_nettype none

module ubps_back #(
	parameter int COUNT_WIDTH = ubps_pkg::COUNT_WIDTH_DEF,
	parameter int LINE_BUFFER = ubps_pkg::LINE_BUFFER_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ubps_pkg::cfg_t   cfg,
	input  wire logic             rd_valid,
	input  wire ubps_pkg::entry_t rd_data,
	output logic                  pop,
	ubps_result_if.source         result
);
	import ubps_pkg::*;

	localparam int CW     = COUNT_WIDTH;
	localparam int DIV_W  = CW + PCT_W;
	localparam int PROD_W = CW + W_BITS;
	localparam int SUM_W  = (CW + 12 > SCORE_W + 1) ? CW + 12 : SCORE_W + 1;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;

	// Window counters and line tracker
	logic [CW-1:0]      byte_cnt_q;
	logic [CW-1:0]      prn_cnt_q;
	logic [CW-1:0]      dollar_cnt_q;
	logic [CW-1:0]      nmea_cnt_q;
	logic [CW-1:0]      ubx_cnt_q;
	logic               prev_sync1_q;
	logic               line_active_q;
	logic [LEN_W-1:0]   line_len_q;
	logic               second_g_q;

	// Report datapath
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dsr_q;
	logic [PCT_W-1:0]   quot_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   acc_q;

	logic               take_data;
	logic               take_close;
	logic               out_free;
	logic [CW-1:0]      mul_opnd;
	logic [W_BITS-1:0]  mul_const;
	logic [PCT_W-1:0]   pct;
	logic               bonus;
	logic               plaus;
	logic [SUM_W-1:0]   sum;
	logic [SCORE_W-1:0] score_sat;

	assign pop        = (state_q == ST_IDLE) && rd_valid;
	assign take_data  = pop && !rd_data.close;
	assign take_close = pop && rd_data.close;
	assign out_free   = !result.valid || result.ready;

	// Report arithmetic from the finished divider and accumulator
	always_comb begin
		pct   = (byte_cnt_q == '0) ? '0 : quot_q;
		bonus = (byte_cnt_q > CW'(cfg.min_bytes)) && (pct >= cfg.pct_min);
		sum   = acc_q + SUM_W'(pct) + (bonus ? SUM_W'(W_BONUS) : '0);
		score_sat = (sum[SUM_W-1:SCORE_W] != '0) ? '1 : sum[SCORE_W-1:0];
		if ((nmea_cnt_q != '0) || (ubx_cnt_q != '0)) begin
			plaus = 1'b1;
		end else if (byte_cnt_q < CW'(cfg.min_bytes)) begin
			plaus = 1'b0;
		end else begin
			plaus = (pct >= cfg.pct_min) && (dollar_cnt_q != '0);
		end
	end

	// One shared multiplier walks the weighted terms
	always_comb begin
		case (step_q)
			STEP_W'(0): begin
				mul_opnd  = dollar_cnt_q;
				mul_const = W_BITS'(W_DOLLAR);
			end
			STEP_W'(1): begin
				mul_opnd  = nmea_cnt_q;
				mul_const = W_BITS'(W_NMEA);
			end
			default: begin
				mul_opnd  = ubx_cnt_q;
				mul_const = W_BITS'(W_UBX);
			end
		endcase
	end

	// Divider and score accumulator
	always_ff @(posedge clk) begin
		if (take_close) begin
			rem_q  <= DIV_W'(prn_cnt_q) * DIV_W'(100);
			dsr_q  <= DIV_W'(byte_cnt_q) << (DIV_STEPS - 1);
			quot_q <= '0;
			acc_q  <= '0;
		end else if (state_q == ST_CALC) begin
			// restoring divide, one quotient bit a step
			if (rem_q >= dsr_q) begin
				rem_q  <= rem_q - dsr_q;
				quot_q <= {quot_q[PCT_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[PCT_W-2:0], 1'b0};
			end
			dsr_q  <= dsr_q >> 1;
			prod_q <= PROD_W'(mul_opnd) * PROD_W'(mul_const);
			if ((step_q >= STEP_W'(1)) && (step_q <= STEP_W'(3))) begin
				acc_q <= acc_q + SUM_W'(prod_q);
			end
		end
	end

	// Control, window state and report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                  <= ST_IDLE;
			step_q                   <= '0;
			byte_cnt_q               <= '0;
			prn_cnt_q                <= '0;
			dollar_cnt_q             <= '0;
			nmea_cnt_q               <= '0;
			ubx_cnt_q                <= '0;
			prev_sync1_q             <= 1'b0;
			line_active_q            <= 1'b0;
			line_len_q               <= '0;
			second_g_q               <= 1'b0;
			result.valid             <= 1'b0;
			result.score             <= '0;
			result.plausible         <= 1'b0;
			result.total_bytes       <= '0;
			result.printable_percent <= '0;
			result.dollar_total      <= '0;
			result.nmea_total        <= '0;
			result.ubx_sync_total    <= '0;
		end else begin
			// a new report is loaded in ST_FINISH instead
			if (result.valid && result.ready && (state_q != ST_FINISH)) begin
				result.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_close) begin
						state_q <= ST_CALC;
						step_q  <= '0;
					end else if (take_data) begin
						if (~&byte_cnt_q) byte_cnt_q <= byte_cnt_q + 1'b1;
						if (rd_data.printable && ~&prn_cnt_q) prn_cnt_q <= prn_cnt_q + 1'b1;
						// NMEA line tracking
						if (rd_data.dollar) begin
							if (~&dollar_cnt_q) dollar_cnt_q <= dollar_cnt_q + 1'b1;
							line_active_q <= 1'b1;
							line_len_q    <= LEN_W'(1);
							second_g_q    <= 1'b0;
						end else if (line_active_q && rd_data.eol) begin
							if ((line_len_q >= LEN_W'(NMEA_MIN_LEN)) && second_g_q
								&& ~&nmea_cnt_q) begin
								nmea_cnt_q <= nmea_cnt_q + 1'b1;
							end
							line_active_q <= 1'b0;
							line_len_q    <= '0;
							second_g_q    <= 1'b0;
						end else if (line_active_q) begin
							if (line_len_q < LEN_W'(LINE_BUFFER - 1)) begin
								if (line_len_q == LEN_W'(1)) second_g_q <= rd_data.is_g;
								line_len_q <= line_len_q + 1'b1;
							end else begin
								line_active_q <= 1'b0;
							end
						end
						// UBX sync pair
						if (prev_sync1_q && rd_data.is_sync2 && ~&ubx_cnt_q) begin
							ubx_cnt_q <= ubx_cnt_q + 1'b1;
						end
						prev_sync1_q <= rd_data.is_sync1;
					end
				end
				ST_CALC: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result.valid             <= 1'b1;
						result.score             <= score_sat;
						result.plausible         <= plaus;
						result.total_bytes       <= TOTAL_W'(byte_cnt_q);
						result.printable_percent <= pct;
						result.dollar_total      <= TOTAL_W'(dollar_cnt_q);
						result.nmea_total        <= TOTAL_W'(nmea_cnt_q);
						result.ubx_sync_total    <= TOTAL_W'(ubx_cnt_q);
						// window closed: start fresh
						byte_cnt_q    <= '0;
						prn_cnt_q     <= '0;
						dollar_cnt_q  <= '0;
						nmea_cnt_q    <= '0;
						ubx_cnt_q     <= '0;
						prev_sync1_q  <= 1'b0;
						line_active_q <= 1'b0;
						line_len_q    <= '0;
						second_g_q    <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_prn_le_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		prn_cnt_q <= byte_cnt_q)
		else $error("printable count above byte count");
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_len_q} < (LEN_W + 1)'(LINE_BUFFER))
		else $error("line length past buffer");
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (pct <= PCT_W'(100)))
		else $error("percentage above 100");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue popped during report");
	a_close_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		take_close |=> (state_q == ST_CALC) && (step_q == '0))
		else $error("close request did not start report");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/uart_baud_plausibility_scorer_core.sv =====
`default_nettype none

// UART baud plausibility scorer. Feed the bytes received during one sampling
// window as data requests; a close request produces one report (score,
// plausible flag, printable percentage and the byte, '$', NMEA line and UBX
// sync counts) and clears the window. The front end classifies and queues a
// request every cycle while its four-entry queue has room. The back end
// retires a data byte in the same cycle that it pops it. A close is picked
// up, then runs the seven steps of the shared restoring divider that forms
// the printable percentage (the weighted terms go through one multiplier in
// the same steps), and then loads the report register when the previous
// report, if any, is taken. Requests behind a close stay in the queue
// meanwhile. No clearing pass is needed after reset.
module uart_baud_plausibility_scorer_core #(
	parameter int COUNT_WIDTH = ubps_pkg::COUNT_WIDTH_DEF,
	parameter int LINE_BUFFER = ubps_pkg::LINE_BUFFER_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [0:0]                   cfg_index,
	input  wire logic [ubps_pkg::BYTE_W-1:0]  cfg_data,
	ubps_item_if.sink                         item,
	ubps_result_if.source                     result
);
	import ubps_pkg::*;

	cfg_t   cfg_q;
	logic   full;
	logic   push;
	entry_t push_data;
	logic   pop;
	logic   rd_valid;
	entry_t rd_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_bytes <= BYTE_W'(20);
			cfg_q.pct_min   <= PCT_W'(70);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN_BYTES: cfg_q.min_bytes <= cfg_data;
				CFG_PCT_MIN:   cfg_q.pct_min   <= cfg_data[PCT_W-1:0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	ubps_front u_front (
		.item      (item),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	ubps_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (full),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data)
	);

	ubps_back #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.LINE_BUFFER (LINE_BUFFER)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rd_valid (rd_valid),
		.rd_data  (rd_data),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
	import ubps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MIN_BYTES_RST = 20;
	localparam int PCT_MIN_RST   = 70;
	localparam int IDLE_PCT      = 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam logic [TOTAL_W-1:0] COUNT_TOP = {TOTAL_W{1'b1}};

	// One request as queued for the driver
	typedef struct {
		op_t               op;
		logic [BYTE_W-1:0] data;
	} byte_req_t;

	// One window report
	typedef struct {
		logic [SCORE_W-1:0] score;
		logic               plausible;
		logic [TOTAL_W-1:0] total_bytes;
		logic [PCT_W-1:0]   pct;
		logic [TOTAL_W-1:0] dollars;
		logic [TOTAL_W-1:0] nmea;
		logic [TOTAL_W-1:0] ubx;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_MIN_BYTES;
	logic [BYTE_W-1:0] cfg_data = '0;

	ubps_item_if   item_ch();
	ubps_result_if result_ch();

	uart_baud_plausibility_scorer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Request and report queues, run control
	byte_req_t pending_reqs[$];
	report_t   expected_reports[$];
	byte_req_t drive_req;
	report_t   got_report;
	int        queued_items = 0;
	int        mismatches = 0;
	int        tx_idle_pct = IDLE_PCT;
	int        rx_idle_pct = IDLE_PCT;
	logic      rx_hold_req = 1'b0;
	logic      rx_hold_seen = 1'b0;
	int        rx_hold_left = 0;

	// Mirror of the configuration registers
	logic [BYTE_W-1:0] cfg_min_bytes = BYTE_W'(MIN_BYTES_RST);
	logic [PCT_W-1:0]  cfg_pct_min = PCT_W'(PCT_MIN_RST);

	// Window state mirror
	logic [TOTAL_W-1:0] byte_cnt = '0;
	logic [TOTAL_W-1:0] prt_cnt = '0;
	logic [TOTAL_W-1:0] dol_cnt = '0;
	logic [TOTAL_W-1:0] nmea_cnt = '0;
	logic [TOTAL_W-1:0] ubx_cnt = '0;
	logic [BYTE_W-1:0]  prev_byte = '0;
	logic               have_prev = 1'b0;
	logic               in_line = 1'b0;
	logic [LEN_W-1:0]   line_len = '0;
	logic               g_second = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] c);
		return (c == COUNT_TOP) ? c : c + 1'b1;
	endfunction

	// Window tracker: updates the counters on a data byte, builds the report on a close
	task automatic tally_request(input op_t op, input logic [BYTE_W-1:0] b);
		report_t     rpt;
		logic [63:0] pct;
		logic [63:0] sum;
		if (op == OP_DATA) begin
			byte_cnt = sat_inc(byte_cnt);
			if (b >= CH_SPACE && b <= CH_TILDE)
				prt_cnt = sat_inc(prt_cnt);
			// line tracking
			if (b == CH_DOLLAR) begin
				dol_cnt = sat_inc(dol_cnt);
				in_line = 1'b1;
				line_len = LEN_W'(1);
				g_second = 1'b0;
			end else if (in_line && (b == CH_CR || b == CH_LF)) begin
				if (line_len >= NMEA_MIN_LEN && g_second)
					nmea_cnt = sat_inc(nmea_cnt);
				in_line = 1'b0;
				line_len = '0;
				g_second = 1'b0;
			end else if (in_line) begin
				if (line_len < LINE_BUFFER_DEF - 1) begin
					if (line_len == 1)
						g_second = (b == CH_G);
					line_len = line_len + 1'b1;
				end else begin
					in_line = 1'b0;
				end
			end
			// UBX sync pair
			if (have_prev && prev_byte == UBX_SYNC1 && b == UBX_SYNC2)
				ubx_cnt = sat_inc(ubx_cnt);
			prev_byte = b;
			have_prev = 1'b1;
		end else begin
			pct = 0;
			sum = 0;
			if (byte_cnt != 0) begin
				pct = (64'(prt_cnt) * 64'd100) / 64'(byte_cnt);
				sum = pct + 64'(dol_cnt) * 64'(W_DOLLAR) + 64'(nmea_cnt) * 64'(W_NMEA)
					+ 64'(ubx_cnt) * 64'(W_UBX);
				if (byte_cnt > cfg_min_bytes && pct >= cfg_pct_min)
					sum = sum + 64'(W_BONUS);
				if (sum > 64'hFFFF_FFFF)
					sum = 64'hFFFF_FFFF;
			end
			if (nmea_cnt != 0 || ubx_cnt != 0)
				rpt.plausible = 1'b1;
			else if (byte_cnt < cfg_min_bytes)
				rpt.plausible = 1'b0;
			else
				rpt.plausible = (pct >= cfg_pct_min) && (dol_cnt != 0);
			rpt.score = sum[SCORE_W-1:0];
			rpt.total_bytes = byte_cnt;
			rpt.pct = pct[PCT_W-1:0];
			rpt.dollars = dol_cnt;
			rpt.nmea = nmea_cnt;
			rpt.ubx = ubx_cnt;
			expected_reports.push_back(rpt);
			// window cleared, registers kept
			byte_cnt = '0;
			prt_cnt = '0;
			dol_cnt = '0;
			nmea_cnt = '0;
			ubx_cnt = '0;
			prev_byte = '0;
			have_prev = 1'b0;
			in_line = 1'b0;
			line_len = '0;
			g_second = 1'b0;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Driver: offers the next queued request, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.operation <= OP_DATA;
			item_ch.data_byte <= '0;
		end else begin
			if (item_ch.valid && item_ch.ready)
				tally_request(op_t'(item_ch.operation), item_ch.data_byte);
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					drive_req = pending_reqs.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.operation <= drive_req.op;
					item_ch.data_byte <= drive_req.data;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes reports, checks them, and paces ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report with none expected, expected nothing got score %0d",
						$time, result_ch.score);
					mismatches++;
				end else begin
					got_report = expected_reports.pop_front();
					check_field("score", got_report.score, result_ch.score);
					check_field("plausible", 32'(got_report.plausible), 32'(result_ch.plausible));
					check_field("total_bytes", 32'(got_report.total_bytes),
						32'(result_ch.total_bytes));
					check_field("printable_percent", 32'(got_report.pct),
						32'(result_ch.printable_percent));
					check_field("dollar_total", 32'(got_report.dollars), 32'(result_ch.dollar_total));
					check_field("nmea_total", 32'(got_report.nmea), 32'(result_ch.nmea_total));
					check_field("ubx_sync_total", 32'(got_report.ubx), 32'(result_ch.ubx_sync_total));
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (rx_hold_req != rx_hold_seen) begin
				rx_hold_seen <= rx_hold_req;
				rx_hold_left <= HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		byte_req_t r;
		r.op = OP_DATA;
		r.data = b;
		pending_reqs.push_back(r);
		queued_items++;
	endtask

	// close carries a random byte that must be ignored
	task automatic push_close();
		byte_req_t r;
		r.op = OP_CLOSE;
		r.data = 8'($urandom);
		pending_reqs.push_back(r);
		queued_items++;
	endtask

	task automatic push_printable();
		push_byte(8'($urandom_range(32, 126)));
	endtask

	// NMEA-like line; sometimes unterminated
	task automatic gen_line();
		int body;
		push_byte(CH_DOLLAR);
		if ($urandom_range(3) != 0)
			push_byte(CH_G);
		else
			push_printable();
		body = $urandom_range(0, 9);
		repeat (body) push_printable();
		case ($urandom_range(4))
			0, 1: push_byte(CH_CR);
			2, 3: push_byte(CH_LF);
			default: ;
		endcase
	endtask

	// UBX sync pair, sometimes broken, with a short payload
	task automatic gen_ubx();
		push_byte(UBX_SYNC1);
		if ($urandom_range(3) == 0)
			push_byte(UBX_SYNC1);
		if ($urandom_range(4) != 0)
			push_byte(UBX_SYNC2);
		else
			push_byte(8'($urandom));
		repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
	endtask

	task automatic gen_noise();
		logic [BYTE_W-1:0] specials [6];
		specials = '{CH_CR, CH_LF, CH_DOLLAR, UBX_SYNC1, UBX_SYNC2, CH_G};
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(3) == 0)
				push_byte(specials[$urandom_range(5)]);
			else
				push_byte(8'($urandom));
		end
	endtask

	// mostly printable text byte, with dollars and some binary
	task automatic gen_text_byte();
		if ($urandom_range(9) == 0)
			push_byte(CH_DOLLAR);
		else if ($urandom_range(7) == 0)
			push_byte(8'($urandom));
		else
			push_printable();
	endtask

	// text window of exactly n bytes, opened by a dollar
	task automatic gen_text(input int n);
		if (n > 0)
			push_byte(CH_DOLLAR);
		repeat ((n > 0) ? n - 1 : 0) gen_text_byte();
		push_close();
	endtask

	// one window of at least target bytes, then a close
	task automatic gen_window(input int target);
		int start;
		int style;
		start = queued_items;
		style = $urandom_range(3);
		while (queued_items - start < target) begin
			case (style)
				0, 1: begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5: gen_line();
						6, 7: gen_ubx();
						default: gen_noise();
					endcase
				end
				2: gen_text_byte();
				default: gen_noise();
			endcase
		end
		push_close();
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_BYTES)
			cfg_min_bytes = val;
		else
			cfg_pct_min = val[PCT_W-1:0];
		@(negedge clk);
	endtask

	// wait until every request is taken and every report is back, then settle
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || item_ch.valid || expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Stimulus
	initial begin
		int phase_start;
		int windows;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty window, byte extremes, UBX pair, dollar restart inside a line
		push_close();
		push_byte(CH_CR);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h1F);
		push_byte(CH_SPACE);
		push_byte(CH_TILDE);
		push_byte(8'h7F);
		push_byte(UBX_SYNC1);
		push_byte(UBX_SYNC2);
		push_close();
		push_byte(CH_DOLLAR);
		push_byte(CH_G);
		push_byte("A");
		push_byte(CH_DOLLAR);
		push_byte(CH_G);
		push_byte("N");
		push_byte(CH_G);
		push_byte(CH_G);
		push_byte("A");
		push_byte(CH_LF);
		push_close();
		// directed: line too long for the buffer is abandoned before its CR
		push_byte(CH_DOLLAR);
		push_byte(CH_G);
		repeat (94) push_byte("A");
		push_byte(CH_CR);
		push_close();

		// random windows under several register settings
		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
				0: begin
					write_reg(CFG_MIN_BYTES, 8'd0);
					write_reg(CFG_PCT_MIN, 8'd0);
				end
				1: begin
					write_reg(CFG_MIN_BYTES, 8'd255);
					write_reg(CFG_PCT_MIN, 8'd100);
				end
				2: begin
					write_reg(CFG_MIN_BYTES, 8'd20);
					write_reg(CFG_PCT_MIN, 8'hFF);
				end
				3: begin
					write_reg(CFG_MIN_BYTES, 8'($urandom));
					write_reg(CFG_PCT_MIN, 8'($urandom));
				end
				4: begin
					write_reg(CFG_MIN_BYTES, 8'($urandom_range(0, 40)));
					write_reg(CFG_PCT_MIN, 8'($urandom_range(50, 101)));
				end
				default: begin
					write_reg(CFG_MIN_BYTES, 8'(MIN_BYTES_RST));
					write_reg(CFG_PCT_MIN, 8'(PCT_MIN_RST));
				end
			endcase
			// long stretch with no idling on either side
			tx_idle_pct = (p == 1) ? 0 : IDLE_PCT;
			rx_idle_pct = (p == 1) ? 0 : IDLE_PCT;
			phase_start = queued_items;
			if (p == 0)
				push_close();
			// windows right at the byte threshold, kept to small thresholds
			if (cfg_min_bytes <= 8'd40) begin
				gen_text(int'(cfg_min_bytes));
				gen_text(int'(cfg_min_bytes) + 1);
			end
			// receiver holds off while short windows keep coming, so the block backs up
			if (p == 2) begin
				tx_idle_pct = 0;
				rx_hold_req = ~rx_hold_req;
				repeat (10) begin
					repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
					push_close();
				end
			end
			windows = 0;
			while (queued_items - phase_start < ((p == 1) ? 70 : 30) || windows < 2) begin
				gen_window($urandom_range(0, 20));
				windows++;
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/ubps_pkg.sv
rtl/core/ubps_if.sv
rtl/core/ubps_front.sv
rtl/core/ubps_fifo.sv
rtl/core/ubps_back.sv
rtl/core/uart_baud_plausibility_scorer_core.sv
bench/tb.sv
